>>> rtl/core/bhx_pkg.sv
// ----------------------------------------------------------------------------
// bhx_pkg
// Shared types and constants for the BinHex 4.0 decoder with run expansion
// and CRC-16.
// ----------------------------------------------------------------------------
package bhx_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  RUN_MARKER = 8'h90;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;

  localparam logic [7:0] ALPHABET [64] = '{
    8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
    8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5A, 8'h5B,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
    8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h70, 8'h71, 8'h72
  };

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FINAL = 2'd2,
    OP_RESET = 2'd3
  } in_op_t;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_END   = 2'd2,
    KIND_BAD   = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    CMD_RUN   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    res_kind_t  kind;
    logic [7:0] data;
    logic [7:0] copies;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_req_t;

endpackage

>>> rtl/core/bhx_if.sv
// ----------------------------------------------------------------------------
// bhx_in_if / bhx_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bhx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] text_char;

  modport source (output valid, output operation, output text_char, input ready);
  modport sink   (input valid, input operation, input text_char, output ready);
endinterface

interface bhx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [7:0]  copies;
  logic [15:0] check_value;
  logic        last_of_step;

  modport source (output valid, output kind, output byte_value, output copies,
                  output check_value, output last_of_step, input ready);
  modport sink   (input valid, input kind, input byte_value, input copies,
                  input check_value, input last_of_step, output ready);
endinterface

>>> rtl/core/bhx_front.sv
// ----------------------------------------------------------------------------
// bhx_front
// Accepts items, decodes characters into raw bytes, applies the run-length
// stage and issues back-end commands one per cycle while the queue takes them.
// ----------------------------------------------------------------------------
module bhx_front (
  input  logic            clk,
  input  logic            rst_n,
  bhx_in_if.sink          in_ch,
  output bhx_pkg::q_req_t push,
  input  logic            push_ready
);
  import bhx_pkg::*;

  logic [1:0]  scount_r, scount_nxt;
  logic [17:0] sbuf_r, sbuf_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        mark_r, mark_nxt;
  logic        ended_r, ended_nxt;

  cmd_t        pend_r [3];
  cmd_t        pend_nxt [3];
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [1:0]  pidx_r, pidx_nxt;

  logic        in_fire;
  logic        sym_ok;
  logic [5:0]  sym;
  logic [7:0]  rb [3];
  logic [2:0]  rb_vld;
  logic        end_req;
  res_kind_t   end_kind;
  logic [23:0] word;
  logic [7:0]  p;
  logic        m;
  logic [1:0]  n;
  cmd_t        cmds [3];

  function automatic cmd_t mk_cmd(cmd_op_t op, res_kind_t kind, logic [7:0] data,
                                  logic [7:0] copies);
    cmd_t c;
    c.op     = op;
    c.kind   = kind;
    c.data   = data;
    c.copies = copies;
    c.last   = 1'b0;
    return c;
  endfunction

  assign in_ch.ready = (pcnt_r == 2'd0);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    sym_ok = 1'b0;
    sym    = '0;
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[i] == in_ch.text_char) begin
        sym_ok = 1'b1;
        sym    = 6'(i);
      end
    end
  end

  always_comb begin
    scount_nxt = scount_r;
    sbuf_nxt   = sbuf_r;
    ended_nxt  = ended_r;
    rb[0]      = '0;
    rb[1]      = '0;
    rb[2]      = '0;
    rb_vld     = '0;
    end_req    = 1'b0;
    end_kind   = KIND_END;
    word       = {sbuf_r, sym};
    p          = prev_r;
    m          = mark_r;
    n          = '0;
    for (int i = 0; i < 3; i++) cmds[i] = mk_cmd(CMD_RUN, KIND_RUN, 8'd0, 8'd0);

    if (in_fire && in_ch.operation == OP_CHAR && !ended_r &&
        in_ch.text_char != CHAR_LF && in_ch.text_char != CHAR_CR) begin
      if (in_ch.text_char == CHAR_COLON || !sym_ok) begin
        end_req  = 1'b1;
        end_kind = (in_ch.text_char == CHAR_COLON) ? KIND_END : KIND_BAD;
        if (scount_r == 2'd2) begin
          rb[0]     = sbuf_r[11:4];
          rb_vld[0] = 1'b1;
        end else if (scount_r == 2'd3) begin
          rb[0]     = sbuf_r[17:10];
          rb[1]     = sbuf_r[9:2];
          rb_vld[1:0] = 2'b11;
        end
        scount_nxt = '0;
        sbuf_nxt   = '0;
        ended_nxt  = 1'b1;
      end else if (scount_r != 2'd3) begin
        sbuf_nxt   = {sbuf_r[11:0], sym};
        scount_nxt = scount_r + 2'd1;
      end else begin
        rb[0]      = word[23:16];
        rb[1]      = word[15:8];
        rb[2]      = word[7:0];
        rb_vld     = 3'b111;
        scount_nxt = '0;
        sbuf_nxt   = '0;
      end
    end

    for (int i = 0; i < 3; i++) begin
      if (rb_vld[i]) begin
        if (m) begin
          m = 1'b0;
          if (rb[i] == 8'd0) begin
            p       = RUN_MARKER;
            cmds[n] = mk_cmd(CMD_RUN, KIND_RUN, RUN_MARKER, 8'd1);
            n       = n + 2'd1;
          end else if (rb[i] >= 8'd2) begin
            cmds[n] = mk_cmd(CMD_RUN, KIND_RUN, p, rb[i] - 8'd1);
            n       = n + 2'd1;
          end
        end else if (rb[i] == RUN_MARKER) begin
          m = 1'b1;
        end else begin
          p       = rb[i];
          cmds[n] = mk_cmd(CMD_RUN, KIND_RUN, rb[i], 8'd1);
          n       = n + 2'd1;
        end
      end
    end

    if (end_req) begin
      m       = 1'b0;
      cmds[n] = mk_cmd(CMD_MARK, end_kind, 8'd0, 8'd0);
      n       = n + 2'd1;
    end

    if (in_fire && in_ch.operation == OP_CLEAR) begin
      cmds[0] = mk_cmd(CMD_CLEAR, KIND_RUN, 8'd0, 8'd0);
      n       = 2'd1;
    end
    if (in_fire && in_ch.operation == OP_FINAL) begin
      cmds[0] = mk_cmd(CMD_FINAL, KIND_CHECK, 8'd0, 8'd0);
      n       = 2'd1;
    end

    if (n != 2'd0) cmds[n - 2'd1].last = 1'b1;

    prev_nxt = p;
    mark_nxt = m;
    if (in_fire && in_ch.operation == OP_RESET) begin
      scount_nxt = '0;
      sbuf_nxt   = '0;
      prev_nxt   = '0;
      mark_nxt   = 1'b0;
      ended_nxt  = 1'b0;
    end
  end

  assign push.valid = (pcnt_r != 2'd0);
  assign push.cmd   = pend_r[pidx_r];

  always_comb begin
    pcnt_nxt = pcnt_r;
    pidx_nxt = pidx_r;
    for (int i = 0; i < 3; i++) pend_nxt[i] = pend_r[i];
    if (in_fire) begin
      pcnt_nxt = n;
      pidx_nxt = '0;
      for (int i = 0; i < 3; i++) pend_nxt[i] = cmds[i];
    end else if (push.valid && push_ready) begin
      pcnt_nxt = pcnt_r - 2'd1;
      pidx_nxt = pidx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scount_r <= '0;
      sbuf_r   <= '0;
      prev_r   <= '0;
      mark_r   <= 1'b0;
      ended_r  <= 1'b0;
      pcnt_r   <= '0;
      pidx_r   <= '0;
    end else begin
      scount_r <= scount_nxt;
      sbuf_r   <= sbuf_nxt;
      prev_r   <= prev_nxt;
      mark_r   <= mark_nxt;
      ended_r  <= ended_nxt;
      pcnt_r   <= pcnt_nxt;
      pidx_r   <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) pend_r[i] <= pend_nxt[i];
  end

endmodule

>>> rtl/core/bhx_queue.sv
// ----------------------------------------------------------------------------
// bhx_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bhx_queue #(
  parameter int unsigned DEPTH = bhx_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bhx_pkg::q_req_t push,
  output logic            push_ready,
  output bhx_pkg::q_req_t pop,
  input  logic            pop_ready
);
  import bhx_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_fire, pop_fire;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop.valid  = (count_r != '0);
  assign pop.cmd    = mem_r[rd_ptr_r];
  assign push_fire  = push.valid && push_ready;
  assign pop_fire   = pop.valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_fire) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop_fire)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + CW'(push_fire) - CW'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) mem_r[wr_ptr_r] <= push.cmd;
  end

endmodule

>>> rtl/core/bhx_back.sv
// ----------------------------------------------------------------------------
// bhx_back
// Executes commands: one CRC byte update per cycle for each copy of a run,
// check clear and finalize, and the registered result stage.
// ----------------------------------------------------------------------------
module bhx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bhx_pkg::q_req_t pop,
  output logic            pop_ready,
  bhx_out_if.source       out_ch
);
  import bhx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CRC  = 3'b010,
    ST_DONE = 3'b100
  } back_st_t;

  back_st_t    st_r, st_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;
  logic        slot_free;
  logic        load;
  logic [15:0] load_crc;

  logic        ov_r, ov_nxt;
  res_kind_t   okind_r;
  logic [7:0]  obyte_r;
  logic [7:0]  ocopies_r;
  logic [15:0] ocrc_r;
  logic        olast_r;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
    logic [15:0] t;
    logic        carry;
    t = c;
    for (int i = 7; i >= 0; i--) begin
      carry = t[15];
      t     = {t[14:0], d[i]};
      if (carry) t = t ^ CRC_POLY;
    end
    return t;
  endfunction

  assign crc_upd   = crc_byte(crc_r, cur_r.data);
  assign slot_free = !ov_r || out_ch.ready;
  assign pop_ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    rem_nxt  = rem_r;
    crc_nxt  = crc_r;
    load     = 1'b0;
    load_crc = crc_r;
    unique case (st_r)
      ST_IDLE: begin
        if (pop.valid) begin
          cur_nxt = pop.cmd;
          unique case (pop.cmd.op)
            CMD_CLEAR: crc_nxt = '0;
            CMD_RUN: begin
              rem_nxt = pop.cmd.copies;
              st_nxt  = ST_CRC;
            end
            CMD_FINAL: begin
              rem_nxt = 8'd2;
              st_nxt  = ST_CRC;
            end
            CMD_MARK: st_nxt = ST_DONE;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CRC: begin
        crc_nxt = crc_upd;
        rem_nxt = rem_r - 8'd1;
        if (rem_r == 8'd1) begin
          if (slot_free) begin
            load     = 1'b1;
            load_crc = crc_upd;
            st_nxt   = ST_IDLE;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load)              ov_nxt = 1'b1;
    else if (out_ch.ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      crc_r <= '0;
      ov_r  <= 1'b0;
      rem_r <= '0;
    end else begin
      st_r  <= st_nxt;
      crc_r <= crc_nxt;
      ov_r  <= ov_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load) begin
      okind_r   <= cur_r.kind;
      obyte_r   <= cur_r.data;
      ocopies_r <= cur_r.copies;
      ocrc_r    <= load_crc;
      olast_r   <= cur_r.last;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.kind         = okind_r;
  assign out_ch.byte_value   = obyte_r;
  assign out_ch.copies       = ocopies_r;
  assign out_ch.check_value  = ocrc_r;
  assign out_ch.last_of_step = olast_r;

endmodule

>>> rtl/core/binhex4_char_decoder_rle_crc_unit.sv
// ----------------------------------------------------------------------------
// binhex4_char_decoder_rle_crc_unit
// BinHex 4.0 character decoder with run-length expansion and CRC-16.
//
// in_chan takes items (operation, text_char) on valid & ready. The front
// decodes characters, packs four symbols into three bytes, resolves run
// markers and queues up to three commands per item, one per cycle while the
// queue has room; it takes the next item once those are queued. The back
// part runs the CRC one byte per cycle and takes a new command only once
// the last one is through. Results leave through a registered out_chan
// stage; last_of_step flags an item's final result. A stalled out_chan
// holds its result while the front and the command queue keep taking items
// until the queue fills, then in_chan.ready drops. Reset clears the decoder
// state, the CRC and all pending items.
// ----------------------------------------------------------------------------
module binhex4_char_decoder_rle_crc_unit #(
  parameter int unsigned QUEUE_DEPTH = bhx_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  bhx_in_if.sink     in_chan,
  bhx_out_if.source  out_chan
);
  import bhx_pkg::*;

  q_req_t q_push;
  q_req_t q_pop;
  logic   q_push_ready;
  logic   q_pop_ready;

  bhx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .push       (q_push),
    .push_ready (q_push_ready)
  );

  bhx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_ready  (q_pop_ready)
  );

  bhx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (q_pop),
    .pop_ready (q_pop_ready),
    .out_ch    (out_chan)
  );

  a_no_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |-> !q_push.valid)
    else $error("front pushed while taking an item");

  a_final_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.operation == OP_FINAL |=>
    q_push.valid && q_push.cmd.op == CMD_FINAL && q_push.cmd.last)
    else $error("finalize item did not issue a finalize command");

  a_reset_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.operation == OP_RESET |=>
    !q_push.valid && in_chan.ready)
    else $error("decoder reset item issued a command");

endmodule

>>> verif/bhx_decode_monitor.sv
// ----------------------------------------------------------------------------
// bhx_decode_monitor
// Watches the item and result channels of the BinHex 4.0 decoder. Every
// accepted item runs through a local model of the symbol packing, run
// expansion and CRC-16; the results it yields are queued and each accepted
// result is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module bhx_decode_monitor (
  input  logic        clk,
  input  logic        rst_n,
  bhx_in_if           in_mon,
  bhx_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import bhx_pkg::*;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  byte_value;
    logic [7:0]  copies;
    logic [15:0] check_value;
    logic        last_of_step;
  } decoded_t;

  decoded_t    awaited_results[$];
  int unsigned n_fail = 0;
  int unsigned n_seen = 0;
  int          step_results;

  logic [1:0]  held_syms;
  logic [17:0] sym_bits;
  logic [7:0]  last_byte;
  logic        run_armed;
  logic        stream_done;
  logic [15:0] crc;

  function automatic logic [15:0] crc_shift_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] t;
    t = c;
    for (int i = 7; i >= 0; i--) t = {t[14:0], b[i]} ^ (t[15] ? CRC_POLY : 16'h0000);
    return t;
  endfunction

  function automatic int sym_value(logic [7:0] c);
    int v;
    v = -1;
    if (c >= 8'h21 && c <= 8'h2D) v = c - 8'h21;
    else if (c >= 8'h30 && c <= 8'h36) v = c - 8'h30 + 13;
    else if (c == 8'h38 || c == 8'h39) v = c - 8'h38 + 20;
    else if (c >= 8'h40 && c <= 8'h4E) v = c - 8'h40 + 22;
    else if (c >= 8'h50 && c <= 8'h56) v = c - 8'h50 + 37;
    else if (c >= 8'h58 && c <= 8'h5B) v = c - 8'h58 + 44;
    else if (c >= 8'h60 && c <= 8'h66) v = c - 8'h60 + 48;
    else if (c >= 8'h68 && c <= 8'h6D) v = c - 8'h68 + 55;
    else if (c >= 8'h70 && c <= 8'h72) v = c - 8'h70 + 61;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    n_fail++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic push_result(res_kind_t k, logic [7:0] b, logic [7:0] n);
    decoded_t r;
    if (step_results < 3) begin
      r = '{kind: k, byte_value: b, copies: n, check_value: crc, last_of_step: 1'b0};
      awaited_results.push_back(r);
      step_results++;
    end
  endtask

  task automatic expand_run(logic [7:0] b, logic [7:0] n);
    for (int i = 0; i < n; i++) crc = crc_shift_byte(crc, b);
    push_result(KIND_RUN, b, n);
  endtask

  task automatic take_byte(logic [7:0] b);
    if (run_armed) begin
      run_armed = 1'b0;
      if (b == 8'h00) begin
        last_byte = RUN_MARKER;
        expand_run(RUN_MARKER, 8'd1);
      end else if (b >= 8'd2) begin
        expand_run(last_byte, b - 8'd1);
      end
    end else if (b == RUN_MARKER) begin
      run_armed = 1'b1;
    end else begin
      last_byte = b;
      expand_run(b, 8'd1);
    end
  endtask

  task automatic close_stream(res_kind_t k);
    if (held_syms == 2'd2) begin
      take_byte(sym_bits[11:4]);
    end else if (held_syms == 2'd3) begin
      take_byte(sym_bits[17:10]);
      take_byte(sym_bits[9:2]);
    end
    held_syms   = 2'd0;
    sym_bits    = '0;
    run_armed   = 1'b0;
    stream_done = 1'b1;
    push_result(k, 8'h00, 8'h00);
  endtask

  task automatic take_char(logic [7:0] c);
    int          v;
    logic [23:0] w;
    if (stream_done || c == CHAR_LF || c == CHAR_CR) return;
    if (c == CHAR_COLON) begin
      close_stream(KIND_END);
      return;
    end
    v = sym_value(c);
    if (v < 0) begin
      close_stream(KIND_BAD);
      return;
    end
    if (held_syms < 2'd3) begin
      sym_bits  = {sym_bits[11:0], v[5:0]};
      held_syms = held_syms + 2'd1;
      return;
    end
    w         = {sym_bits, v[5:0]};
    held_syms = 2'd0;
    sym_bits  = '0;
    take_byte(w[23:16]);
    take_byte(w[15:8]);
    take_byte(w[7:0]);
  endtask

  task automatic clear_decoder();
    held_syms   = 2'd0;
    sym_bits    = '0;
    last_byte   = 8'h00;
    run_armed   = 1'b0;
    stream_done = 1'b0;
  endtask

  task automatic decode_item(in_op_t op, logic [7:0] c);
    int base;
    base         = awaited_results.size();
    step_results = 0;
    case (op)
      OP_CHAR: take_char(c);
      OP_CLEAR: crc = 16'h0000;
      OP_FINAL: begin
        crc = crc_shift_byte(crc_shift_byte(crc, 8'h00), 8'h00);
        push_result(KIND_CHECK, 8'h00, 8'h00);
      end
      default: clear_decoder();
    endcase
    if (awaited_results.size() > base) awaited_results[$].last_of_step = 1'b1;
  endtask

  task automatic check_result(decoded_t got);
    decoded_t want;
    n_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %0d unexpected: kind %0d byte %02h copies %0d check %04h",
                                n_seen, got.kind, got.byte_value, got.copies, got.check_value));
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("result %0d kind %0d, expected %0d", n_seen, got.kind, want.kind));
    if (got.byte_value !== want.byte_value)
      report_mismatch($sformatf("result %0d byte_value %02h, expected %02h",
                                n_seen, got.byte_value, want.byte_value));
    if (got.copies !== want.copies)
      report_mismatch($sformatf("result %0d copies %0d, expected %0d",
                                n_seen, got.copies, want.copies));
    if (got.check_value !== want.check_value)
      report_mismatch($sformatf("result %0d check_value %04h, expected %04h",
                                n_seen, got.check_value, want.check_value));
    if (got.last_of_step !== want.last_of_step)
      report_mismatch($sformatf("result %0d last_of_step %0b, expected %0b",
                                n_seen, got.last_of_step, want.last_of_step));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      crc = 16'h0000;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_result('{kind: res_kind_t'(out_mon.kind), byte_value: out_mon.byte_value,
                       copies: out_mon.copies, check_value: out_mon.check_value,
                       last_of_step: out_mon.last_of_step});
      if (in_mon.valid && in_mon.ready)
        decode_item(in_op_t'(in_mon.operation), in_mon.text_char);
    end
    pending    = awaited_results.size();
    fail_count = n_fail;
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for binhex4_char_decoder_rle_crc_unit. A short
// directed sequence covers runs, literal and dangling markers, partial groups
// and every operation; then encoded streams with random content, line breaks,
// endings and noise run through phases of sender idling and receiver stalls,
// including one long receiver hold. bhx_decode_monitor does the checking.
// ----------------------------------------------------------------------------
module tb;
  import bhx_pkg::*;

  localparam int WATCH_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  typedef logic [7:0] byte_q_t[$];

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_reqs     = 0;
  int unsigned items_sent    = 0;
  int          idle_cycles;

  bhx_in_if  in_chan ();
  bhx_out_if out_chan ();

  binhex4_char_decoder_rle_crc_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bhx_decode_monitor mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(in_op_t op, logic [7:0] c, bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.text_char <= c;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_sym(logic [5:0] s, int unsigned crlf_pct);
    if ($urandom_range(99) < crlf_pct)
      send_item(OP_CHAR, $urandom_range(1) ? CHAR_LF : CHAR_CR, 1'b0);
    send_item(OP_CHAR, ALPHABET[s], 1'b1);
  endtask

  // 3 bytes -> 4 symbols; a tail of 1 or 2 bytes -> 2 or 3 symbols, random pad
  task automatic send_bytes(byte_q_t data, bit odd_sym, int unsigned crlf_pct);
    int          i;
    int          nsym;
    logic [23:0] w;
    i = 0;
    while (i < data.size()) begin
      if (data.size() - i >= 3) begin
        w    = {data[i], data[i+1], data[i+2]};
        nsym = 4;
        i += 3;
      end else if (data.size() - i == 2) begin
        w    = {6'd0, data[i], data[i+1], 2'($urandom)};
        nsym = 3;
        i += 2;
      end else begin
        w    = {12'd0, data[i], 4'($urandom)};
        nsym = 2;
        i += 1;
      end
      for (int k = nsym - 1; k >= 0; k--) send_sym(w[6*k +: 6], crlf_pct);
    end
    if (odd_sym) send_sym(6'($urandom), crlf_pct);
  endtask

  function automatic logic [7:0] bad_char();
    logic [7:0] gaps [12] = '{8'h2E, 8'h2F, 8'h37, 8'h4F, 8'h57, 8'h5C,
                              8'h5D, 8'h5E, 8'h5F, 8'h67, 8'h6E, 8'h6F};
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = 8'h00;
      1: c = 8'($urandom_range(9));
      2: c = 8'($urandom_range(8'h20, 8'h0E));
      3: c = 8'($urandom_range(8'h3F, 8'h3B));
      4: c = 8'($urandom_range(8'hFF, 8'h73));
      default: c = gaps[$urandom_range(11)];
    endcase
    return c;
  endfunction

  function automatic logic [7:0] run_count();
    logic [7:0] n;
    case ($urandom_range(19))
      0: n = 8'd0;
      1: n = 8'd1;
      2: n = 8'd2;
      3: n = 8'd255;
      4: n = 8'($urandom_range(254, 100));
      default: n = 8'($urandom_range(12, 3));
    endcase
    return n;
  endfunction

  task automatic random_stream();
    byte_q_t     data;
    int unsigned len;
    int unsigned r;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(8, 1)) send_item(in_op_t'($urandom_range(3)), 8'($urandom), 1'b1);
      return;
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    while (data.size() < len) begin
      r = $urandom_range(99);
      if (r < 55) begin
        data.push_back(8'($urandom));
      end else if (r < 80) begin
        data.push_back(8'($urandom));
        data.push_back(RUN_MARKER);
        data.push_back(run_count());
      end else if (r < 90) begin
        data.push_back(RUN_MARKER);
        data.push_back(8'h00);
      end else if (r < 95) begin
        data.push_back(RUN_MARKER);
      end else begin
        data.push_back(8'($urandom_range(255, 250)));
      end
    end
    if ($urandom_range(4) != 0) send_item(OP_RESET, 8'($urandom), 1'b1);
    if ($urandom_range(5) == 0) send_item(OP_CLEAR, 8'($urandom), 1'b1);
    send_bytes(data, $urandom_range(5) == 0, 5);
    r = $urandom_range(19);
    if (r < 17) begin
      send_item(OP_CHAR, (r < 14) ? CHAR_COLON : bad_char(), 1'b1);
      // chars after the end are dropped by the block
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) send_item(OP_CHAR, 8'($urandom), 1'b0);
    end
    if ($urandom_range(1)) send_item(OP_FINAL, 8'($urandom), 1'b1);
  endtask

  initial begin
    int unsigned served;
    int unsigned hold_left;
    served         = 0;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != served) begin
        served    = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("binhex4_char_decoder_rle_crc_unit: mismatch");
    $finish;
  end

  initial begin
    byte_q_t     seq;
    int unsigned goal;
    int unsigned idle_by_phase [4];
    int unsigned stall_by_phase [4];
    idle_by_phase     = '{0, 75, 0, 26};
    stall_by_phase    = '{0, 0, 75, 26};
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_CHAR;
    in_chan.text_char = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_FINAL, 8'h00, 1'b1);
    send_item(OP_CLEAR, 8'hFF, 1'b1);
    // plain byte, count of one, literal marker, marker left dangling at the colon
    seq = {8'h41, RUN_MARKER, 8'h01, RUN_MARKER, 8'h00, RUN_MARKER};
    send_bytes(seq, 1'b0, 0);
    send_item(OP_CHAR, CHAR_COLON, 1'b1);
    send_item(OP_CHAR, 8'h21, 1'b0);
    // two held symbols flushed by NUL
    send_item(OP_RESET, 8'h00, 1'b1);
    seq = {8'hC3};
    send_bytes(seq, 1'b0, 0);
    send_item(OP_CHAR, 8'h00, 1'b1);
    // longest run, then three held symbols flushed by a bad char
    send_item(OP_RESET, 8'hFF, 1'b1);
    seq = {8'h00, RUN_MARKER, 8'hFF, 8'h5A, 8'hA5};
    send_bytes(seq, 1'b0, 0);
    send_item(OP_CHAR, 8'hFF, 1'b1);
    send_item(OP_FINAL, 8'hFF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      if (ph == 0) hold_reqs++;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_stream();
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("binhex4_char_decoder_rle_crc_unit: match");
    else
      $display("binhex4_char_decoder_rle_crc_unit: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bhx_pkg.sv
rtl/core/bhx_if.sv
rtl/core/bhx_front.sv
rtl/core/bhx_queue.sv
rtl/core/bhx_back.sv
rtl/core/binhex4_char_decoder_rle_crc_unit.sv
verif/bhx_decode_monitor.sv
verif/tb.sv
